@@ src/tfun_pkg.sv @@
`timescale 1ns / 1ps

package tfun_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 8;
    localparam int CNT_W        = 7;
    localparam int COORD_W      = 16;
    localparam int VERT_W       = 3 * COORD_W;
    localparam int EDGE_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int NORM_W       = 31;
    localparam int SUM_W        = 64;
    localparam int FRAC_W       = 14;
    localparam int LEN_W        = 32;
    localparam int NUM_W        = LEN_W + FRAC_W;
    localparam int QUO_W        = FRAC_W + 1;
    localparam int OUT_W        = 16;
    localparam int STEP_W       = 6;
    localparam int IN_DATA_W    = 80;
    localparam int OUT_DATA_W   = 48;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_FACE   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    localparam logic [STEP_W-1:0] READ_LAST  = STEP_W'(4);
    localparam logic [STEP_W-1:0] CROSS_LAST = STEP_W'(5);
    localparam logic [STEP_W-1:0] SQS_LAST   = STEP_W'(2);
    localparam logic [STEP_W-1:0] SQRT_LAST  = STEP_W'(31);
    localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(47);

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_READ,
        OP_CROSS,
        OP_ABS,
        OP_NORM,
        OP_SQSUM,
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic              take;
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic zero;
        logic norm_done;
    } stat_t;

endpackage

@@ src/tfun_ctrl.sv @@
`timescale 1ns / 1ps

module tfun_ctrl
    import tfun_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  req_type,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_CROSS = 9'b000000100,
        S_ABS   = 9'b000001000,
        S_NORM  = 9'b000010000,
        S_SQSUM = 9'b000100000,
        S_SQRT  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              take;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + STEP_W'(1);
        cmd.take   = take;
        cmd.step   = step_reg;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (take && req_type == REQ_FACE)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.op = OP_READ;
                if (step_reg == '0 && stat.bad)
                begin
                    state_next = S_OUT;
                end
                else if (step_reg == READ_LAST)
                begin
                    state_next = S_CROSS;
                    step_next  = '0;
                end
            end
            S_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (step_reg == CROSS_LAST)
                begin
                    state_next = S_ABS;
                end
            end
            S_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op    = OP_NORM;
                step_next = '0;
                if (stat.zero)
                begin
                    state_next = S_OUT;
                end
                else if (stat.norm_done)
                begin
                    state_next = S_SQSUM;
                end
            end
            S_SQSUM:
            begin
                cmd.op = OP_SQSUM;
                if (step_reg == SQS_LAST)
                begin
                    state_next = S_SQRT;
                    step_next  = '0;
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_DIV;
                    step_next  = '0;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ src/tfun_dp.sv @@
`timescale 1ns / 1ps

module tfun_dp
    import tfun_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  req_type,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser
);

    logic [VERT_W-1:0]        mem [MAX_VERTICES];
    logic [VERT_W-1:0]        rd_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     abort_reg;
    logic [IDX_W-1:0]         ca_reg, cb_reg, cc_reg;
    logic [VERT_W-1:0]        pa_reg, pb_reg, pc_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CROSS_W-1:0] cr_reg [3];
    logic [CROSS_W-1:0]       u_reg [3];
    logic                     neg_reg [3];
    logic [SUM_W-1:0]         sum_reg, res_reg, bit_reg;
    logic [NUM_W-1:0]         num_reg, dvs_reg;
    logic [QUO_W-1:0]         q_reg;
    logic signed [OUT_W-1:0]  n_reg [3];
    logic [1:0]               st_reg;

    logic [IDX_W-1:0]         vidx;
    logic [CNT_W-1:0]         limit;
    logic signed [EDGE_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [NORM_W-1:0]        usel;
    logic [2*NORM_W-1:0]      sq;
    logic [SUM_W-1:0]         trial;
    logic                     big, ready_norm;
    logic                     dbit;
    logic [QUO_W-1:0]         q_fin;
    logic [1:0]               j;

    assign vidx  = s_tdata[7:0];
    assign limit = (cnt_reg > MAX_CNT) ? MAX_CNT : cnt_reg;

    assign stat.bad = abort_reg || ca_reg >= IDX_W'(limit) || cb_reg >= IDX_W'(limit)
                      || cc_reg >= IDX_W'(limit);
    assign stat.zero = (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);

    assign big = (u_reg[0][CROSS_W-1:NORM_W] != '0) || (u_reg[1][CROSS_W-1:NORM_W] != '0)
                 || (u_reg[2][CROSS_W-1:NORM_W] != '0);
    assign ready_norm = u_reg[0][NORM_W-1] || u_reg[1][NORM_W-1] || u_reg[2][NORM_W-1];
    assign stat.norm_done = !big && ready_norm;

    always_comb
    begin
        unique case (cmd.step[1:0])
            2'd0:    rd_addr = ca_reg[ADDR_W-1:0];
            2'd1:    rd_addr = cb_reg[ADDR_W-1:0];
            default: rd_addr = cc_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        unique case (cmd.step[2:0])
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            3'd5:    begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        j = (cmd.op == OP_DIV) ? cmd.step[5:4] : cmd.step[1:0];
        unique case (j)
            2'd0:    usel = u_reg[0][NORM_W-1:0];
            2'd1:    usel = u_reg[1][NORM_W-1:0];
            default: usel = u_reg[2][NORM_W-1:0];
        endcase
    end

    assign sq    = usel * usel;
    assign trial = res_reg + bit_reg;
    assign dbit  = (num_reg >= dvs_reg);
    assign q_fin = {q_reg[QUO_W-2:0], dbit};

    // vertex store
    always_ff @(posedge clk)
    begin
        if (cmd.take && req_type == REQ_VERTEX && vidx < IDX_W'(MAX_VERTICES))
        begin
            mem[vidx[ADDR_W-1:0]] <= s_tdata[8 +: VERT_W];
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            abort_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_reg <= cfg_wdata;
            end
            if (cmd.take && req_type == REQ_VERTEX)
            begin
                abort_reg <= 1'b0;
            end
            else if (cmd.op == OP_READ && cmd.step == '0 && stat.bad)
            begin
                abort_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ca_reg <= s_tdata[56 +: IDX_W];
            cb_reg <= s_tdata[64 +: IDX_W];
            cc_reg <= s_tdata[72 +: IDX_W];
        end
        unique case (cmd.op)
            OP_READ:
            begin
                if (cmd.step == '0 && stat.bad)
                begin
                    st_reg <= ST_BAD;
                    for (int i = 0; i < 3; i++)
                    begin
                        n_reg[i] <= '0;
                    end
                end
                unique case (cmd.step[2:0])
                    3'd1: pa_reg <= rd_reg;
                    3'd2: pb_reg <= rd_reg;
                    3'd3: pc_reg <= rd_reg;
                    3'd4:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_reg[i] <= EDGE_W'($signed(pb_reg[i*COORD_W +: COORD_W]))
                                       - EDGE_W'($signed(pa_reg[i*COORD_W +: COORD_W]));
                            e2_reg[i] <= EDGE_W'($signed(pc_reg[i*COORD_W +: COORD_W]))
                                       - EDGE_W'($signed(pa_reg[i*COORD_W +: COORD_W]));
                        end
                    end
                    default: ;
                endcase
            end
            OP_CROSS:
            begin
                if (!cmd.step[0])
                begin
                    prod_reg <= prod;
                end
                else
                begin
                    unique case (cmd.step[2:1])
                        2'd0:    cr_reg[0] <= CROSS_W'(prod_reg) - CROSS_W'(prod);
                        2'd1:    cr_reg[1] <= CROSS_W'(prod_reg) - CROSS_W'(prod);
                        default: cr_reg[2] <= CROSS_W'(prod_reg) - CROSS_W'(prod);
                    endcase
                end
            end
            OP_ABS:
            begin
                st_reg <= ST_OK;
                for (int i = 0; i < 3; i++)
                begin
                    u_reg[i]   <= cr_reg[i][CROSS_W-1] ? -cr_reg[i] : cr_reg[i];
                    neg_reg[i] <= cr_reg[i][CROSS_W-1];
                end
            end
            OP_NORM:
            begin
                if (stat.zero)
                begin
                    st_reg <= ST_DEGEN;
                    for (int i = 0; i < 3; i++)
                    begin
                        n_reg[i] <= '0;
                    end
                end
                else if (big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= u_reg[i] >> 1;
                    end
                end
                else if (!ready_norm)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= u_reg[i] << 1;
                    end
                end
                res_reg <= '0;
                bit_reg <= SUM_W'(1) << (SUM_W - 2);
            end
            OP_SQSUM:
            begin
                sum_reg <= ((cmd.step == '0) ? '0 : sum_reg) + SUM_W'(sq);
            end
            OP_SQRT:
            begin
                if (sum_reg >= trial)
                begin
                    sum_reg <= sum_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV:
            begin
                if (cmd.step[3:0] == '0)
                begin
                    num_reg <= NUM_W'({usel, {FRAC_W{1'b0}}})
                             + NUM_W'(res_reg[LEN_W-1:1]);
                    dvs_reg <= {res_reg[LEN_W-1:0], {FRAC_W{1'b0}}};
                    q_reg   <= '0;
                end
                else
                begin
                    if (dbit)
                    begin
                        num_reg <= num_reg - dvs_reg;
                    end
                    dvs_reg <= dvs_reg >> 1;
                    q_reg   <= q_fin;
                    if (cmd.step[3:0] == 4'hF)
                    begin
                        unique case (j)
                            2'd0:    n_reg[0] <= neg_reg[0] ? -OUT_W'(q_fin) : OUT_W'(q_fin);
                            2'd1:    n_reg[1] <= neg_reg[1] ? -OUT_W'(q_fin) : OUT_W'(q_fin);
                            default: n_reg[2] <= neg_reg[2] ? -OUT_W'(q_fin) : OUT_W'(q_fin);
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {n_reg[2], n_reg[1], n_reg[0]};
    assign m_tuser = st_reg;

endmodule

@@ src/triangle_face_unit_normal.sv @@
`timescale 1ns / 1ps

// channel  | dir | beat contents
// s_axis   | in  | tuser: req_type; tdata: vertex_index, coord x/y/z, corners a/b/c
// m_axis   | out | tuser: status; tdata: normal x/y/z
// cfg      | in  | vertex_count
//
// vertex write: stored at the accepting edge; indices of 64 and above are dropped
// face: corner reads, cross product, abs, normalization, sum of squares, then the root and
// the divider, both bit-serial, before the result beat
// a bad index reports from the read state, a degenerate face from normalization
// one face at a time; s_tready low until the result beat is taken
// reset clears control, vertex_count and the abort flag; the vertex store is not cleared

module triangle_face_unit_normal
    import tfun_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // vertex_index, coord_x, coord_y, coord_z,
                                            // corner_a, corner_b, corner_c
    input  logic [0:0]            s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // normal_x, normal_y, normal_z
    output logic [1:0]            m_tuser,  // status
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    tfun_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfun_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .req_type  (s_tuser[0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ test/face_normal_checker.sv @@
`timescale 1ns / 1ps

module face_normal_checker
    import tfun_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    output int                    errors,
    output int                    pending
);

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [1:0]  status;
    } normal_t;

    logic [VERT_W-1:0] vertices [MAX_VERTICES];
    logic              aborted;
    logic [CNT_W-1:0]  valid_count;
    normal_t           expected_normals [$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic normal_t face_normal(logic [IDX_W-1:0] ca, logic [IDX_W-1:0] cb,
                                            logic [IDX_W-1:0] cc);
        normal_t           r;
        logic [IDX_W-1:0]  id [3];
        longint signed     p [3][3];
        longint signed     e1 [3];
        longint signed     e2 [3];
        longint signed     cr [3];
        longint unsigned   u [3];
        longint unsigned   m;
        longint unsigned   sum;
        longint unsigned   len;
        longint unsigned   q;
        logic [15:0]       comp [3];
        int                lim;
        r.nx = '0;
        r.ny = '0;
        r.nz = '0;
        r.status = ST_OK;
        id[0] = ca;
        id[1] = cb;
        id[2] = cc;
        lim = (valid_count > MAX_VERTICES) ? MAX_VERTICES : int'(valid_count);
        if (aborted || ca >= lim || cb >= lim || cc >= lim)
        begin
            aborted = 1'b1;
            r.status = ST_BAD;
            return r;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = longint'($signed(vertices[id[i][ADDR_W-1:0]][16*j +: 16]));
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = p[1][j] - p[0][j];
            e2[j] = p[2][j] - p[0][j];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        for (int j = 0; j < 3; j++)
        begin
            u[j] = (cr[j] < 0) ? longint'(-cr[j]) : longint'(cr[j]);
            if (u[j] > m)
                m = u[j];
        end
        if (m == 0)
        begin
            r.status = ST_DEGEN;
            return r;
        end
        while (m >= (64'd1 << 31))
        begin
            m >>= 1;
            for (int j = 0; j < 3; j++)
                u[j] >>= 1;
        end
        while (m < (64'd1 << 30))
        begin
            m <<= 1;
            for (int j = 0; j < 3; j++)
                u[j] <<= 1;
        end
        sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        len = int_sqrt(sum);
        for (int j = 0; j < 3; j++)
        begin
            q = (u[j] * 16384 + (len >> 1)) / len;
            comp[j] = (cr[j] < 0) ? 16'(-q) : 16'(q);
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        return r;
    endfunction

    assign pending = expected_normals.size();

    always @(posedge clk or negedge rst_n)
    begin
        normal_t want;
        if (!rst_n)
        begin
            aborted = 1'b0;
            valid_count = '0;
            errors = 0;
            expected_normals.delete();
        end
        else
        begin
            if (cfg_we)
                valid_count = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_VERTEX)
                begin
                    if (s_tdata[7:0] < MAX_VERTICES)
                        vertices[s_tdata[ADDR_W-1:0]] = s_tdata[55:8];
                    aborted = 1'b0;
                end
                else
                    expected_normals.insert(expected_normals.size(),
                                            face_normal(s_tdata[63:56], s_tdata[71:64],
                                                        s_tdata[79:72]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_normals.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected beat: x=%h y=%h z=%h status=%0d", $time,
                             m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser);
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (want.nx !== m_tdata[15:0] || want.ny !== m_tdata[31:16] ||
                        want.nz !== m_tdata[47:32] || want.status !== m_tuser)
                    begin
                        errors++;
                        $display("%0t mismatch: expected x=%h y=%h z=%h status=%0d",
                                 $time, want.nx, want.ny, want.nz, want.status);
                        $display("%0t           actual   x=%h y=%h z=%h status=%0d",
                                 $time, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                 m_tuser);
                    end
                end
            end
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tfun_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    int                    errors;
    int                    pending;

    int burst_left = 0;
    int face_limit = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    int rx_mode = 0;

    always #6 clk = ~clk;

    triangle_face_unit_normal dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    face_normal_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // receiver stall pattern, with one long hold-off
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle == 4000)
            hold_left = 400;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 5000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(logic req, logic [IN_DATA_W-1:0] data);
        int gap;
        s_tuser  <= req;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic write_vertex(logic [7:0] idx, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z);
        send_beat(REQ_VERTEX, {8'($urandom), 8'($urandom), 8'($urandom), z, y, x, idx});
    endtask

    task automatic face(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        send_beat(REQ_FACE, {c, b, a, 16'($urandom), 16'($urandom), 16'($urandom),
                             8'($urandom)});
    endtask

    task automatic set_vertex_count(logic [CNT_W-1:0] value);
        if (burst_left > 0)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        face_limit = (value > MAX_VERTICES) ? MAX_VERTICES : int'(value);
        burst_left = $urandom_range(1, 20);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_corner();
        if ($urandom_range(0, 9) == 0 || face_limit == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, face_limit - 1));
    endfunction

    task automatic random_item();
        logic [7:0] a;
        if ($urandom_range(0, 9) < 3)
            write_vertex($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 63)),
                         rand_coord(), rand_coord(), rand_coord());
        else if ($urandom_range(0, 7) == 0)
        begin
            a = rand_corner();
            face(a, a, rand_corner());
        end
        else
            face(rand_corner(), rand_corner(), rand_corner());
    endtask

    initial
    begin
        burst_left = $urandom_range(1, 20);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count still zero: every face is a bad index, abort is sticky
        face(8'd0, 8'd0, 8'd0);
        face(8'd0, 8'd0, 8'd0);
        write_vertex(8'd255, 16'h0000, 16'h0000, 16'h0000);
        face(8'd255, 8'd255, 8'd255);

        set_vertex_count(7'd64);
        for (int i = 0; i < MAX_VERTICES; i++)
            write_vertex(8'(i), rand_coord(), rand_coord(), rand_coord());
        write_vertex(8'd0, 16'h8000, 16'h8000, 16'h8000);
        write_vertex(8'd1, 16'h7fff, 16'h8000, 16'h8000);
        write_vertex(8'd2, 16'h8000, 16'h7fff, 16'h8000);
        face(8'd0, 8'd1, 8'd2);
        face(8'd2, 8'd1, 8'd0);
        face(8'd3, 8'd3, 8'd3);
        write_vertex(8'd4, 16'h0001, 16'h0000, 16'h0000);
        write_vertex(8'd5, 16'h0000, 16'h0001, 16'h0000);
        write_vertex(8'd6, 16'h0000, 16'h0000, 16'h0001);
        write_vertex(8'd7, 16'h0002, 16'h0000, 16'h0000);
        face(8'd4, 8'd5, 8'd6);
        face(8'd6, 8'd4, 8'd7);
        face(8'd63, 8'd4, 8'd5);
        face(8'd64, 8'd0, 8'd1);
        face(8'd0, 8'd1, 8'd2);
        write_vertex(8'd64, 16'hffff, 16'hffff, 16'hffff);
        face(8'd0, 8'd1, 8'd2);

        set_vertex_count(7'd127);
        repeat (120) random_item();
        set_vertex_count(7'd3);
        repeat (60) random_item();
        set_vertex_count(7'd1);
        repeat (30) random_item();
        set_vertex_count(7'($urandom_range(2, 63)));
        repeat (90) random_item();
        set_vertex_count(7'd64);
        repeat (120) random_item();

        if (burst_left > 0)
            s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
